@@ rtl/core/u8dc_pkg.sv @@
`default_nettype none
package u8dc_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 16;

  // lead byte patterns
  localparam logic [7:0] LeadMask2 = 8'hE0;
  localparam logic [7:0] LeadVal2  = 8'hC0;
  localparam logic [7:0] LeadMask3 = 8'hF0;
  localparam logic [7:0] LeadVal3  = 8'hE0;
  localparam logic [7:0] LeadMask4 = 8'hF8;
  localparam logic [7:0] LeadVal4  = 8'hF0;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContVal   = 8'h80;
  localparam logic [7:0] ContBits  = 8'h3F;

  typedef enum logic [2:0] {
    KindTerm,
    KindAscii,
    KindLead,
    KindCont,
    KindBad
  } kind_e;

  // classified byte passed from front to back
  typedef struct packed {
    kind_e      kind;
    logic [1:0] lead_len;
    logic [6:0] payload;
  } item_t;

  typedef struct packed {
    logic [CpW-1:0]    code_point;
    logic              point_done;
    logic              is_diacritic;
    logic [CountW-1:0] char_count;
    logic              string_end;
    logic              length_error;
    logic              string_valid;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/core/utf8_stream_decode_count.sv @@
// UTF-8 string decoder and character counter. Push one byte per cycle on
// data_byte_i (0 terminates the string); each byte yields exactly one result
// in the output queue: the completed code point with its combining-mark flag,
// the running character count, the sticky error and, at the terminator, the
// string's validity. Throughput is one byte per cycle as long as results are
// popped at the same rate. The result of a byte reaches the output ports
// through both queues in turn: the classifier writes the byte into the
// classifier queue, and the decoder writes its result into the result
// queue when it takes the byte from there. The classifier queue and the
// result queue hold two items each, so full_o rises only when the result
// side stalls. The mark-skip flag is written through the cfg channel,
// which is always ready; write it only while no string is in flight.
`default_nettype none
module utf8_stream_decode_count #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [20:0]      code_point_o,
  output logic             point_done_o,
  output logic             is_diacritic_o,
  output logic [15:0]      char_count_o,
  output logic             string_end_o,
  output logic             length_error_o,
  output logic             string_valid_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);
  import u8dc_pkg::*;

  item_t item;
  logic  item_valid, item_take;
  res_t  res;

  assign cfg_ready_o = 1'b1;

  u8dc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .data_byte_i  (data_byte_i),
    .full_o       (full_o),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  u8dc_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .item_i       (item),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .res_o        (res)
  );

  assign code_point_o   = res.code_point;
  assign point_done_o   = res.point_done;
  assign is_diacritic_o = res.is_diacritic;
  assign char_count_o   = res.char_count;
  assign string_end_o   = res.string_end;
  assign length_error_o = res.length_error;
  assign string_valid_o = res.string_valid;

endmodule
`default_nettype wire

@@ rtl/core/u8dc_front.sv @@
`default_nettype none
module u8dc_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire logic [7:0]     data_byte_i,
  output logic                full_o,
  output logic                item_valid_o,
  input  wire logic           item_take_i,
  output u8dc_pkg::item_t     item_o
);
  import u8dc_pkg::*;

  item_t      cls;
  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  always_comb begin
    cls.kind     = KindBad;
    cls.lead_len = 2'd0;
    cls.payload  = 7'd0;
    if (data_byte_i == 8'd0) begin
      cls.kind = KindTerm;
    end else if (!data_byte_i[7]) begin
      cls.kind    = KindAscii;
      cls.payload = data_byte_i[6:0];
    end else if ((data_byte_i & ContMask) == ContVal) begin
      cls.kind    = KindCont;
      cls.payload = {1'b0, data_byte_i[5:0] & ContBits[5:0]};
    end else if ((data_byte_i & LeadMask2) == LeadVal2) begin
      cls.kind     = KindLead;
      cls.lead_len = 2'd1;
      cls.payload  = {2'b0, data_byte_i[4:0]};
    end else if ((data_byte_i & LeadMask3) == LeadVal3) begin
      cls.kind     = KindLead;
      cls.lead_len = 2'd2;
      cls.payload  = {3'b0, data_byte_i[3:0]};
    end else if ((data_byte_i & LeadMask4) == LeadVal4) begin
      cls.kind     = KindLead;
      cls.lead_len = 2'd3;
      cls.payload  = {4'b0, data_byte_i[2:0]};
    end
  end

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign wr_en        = push_i && !full_o;
  assign rd_en        = item_take_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/u8dc_back.sv @@
`default_nettype none
module u8dc_back #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  input  wire logic             cfg_data_i,
  input  wire logic             item_valid_i,
  output logic                  item_take_o,
  input  wire u8dc_pkg::item_t  item_i,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output u8dc_pkg::res_t        res_o
);
  import u8dc_pkg::*;

  function automatic logic mark_range(input logic [CpW-1:0] cp);
    mark_range = cp inside {[21'h0300 : 21'h036F], [21'h1AB0 : 21'h1AFF],
                            [21'h1DC0 : 21'h1DFF], [21'h20D0 : 21'h20FF],
                            [21'hFE20 : 21'hFE2F]};
  endfunction

  logic                  skip_q;
  logic [1:0]            rem_q, rem_d;
  logic [CpW-1:0]        part_q, part_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  err_q, err_d;
  logic                  first_q, first_d;
  logic                  fmark_q, fmark_d;
  logic [CpW-1:0]        cp;
  logic [CpW-1:0]        shifted;
  logic                  done, mark, term_err;
  logic [COUNT_BITS+CountW-1:0] cnt_ext;
  res_t                  res_d;

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] ocnt_q;
  logic       rd_en;

  assign item_take_o = item_valid_i && (ocnt_q != 2'd2);
  assign shifted     = {part_q[CpW-7:0], item_i.payload[5:0]};
  assign term_err    = err_q || (rem_q != 2'd0);

  always_comb begin
    rem_d   = rem_q;
    part_d  = part_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    first_d = first_q;
    fmark_d = fmark_q;
    cp      = '0;
    done    = 1'b0;
    mark    = 1'b0;
    if (item_i.kind == KindTerm) begin
      rem_d   = 2'd0;
      part_d  = '0;
      cnt_d   = '0;
      err_d   = 1'b0;
      first_d = 1'b0;
      fmark_d = 1'b0;
    end else if (!err_q) begin
      if (rem_q == 2'd0) begin
        case (item_i.kind)
          KindAscii: begin
            cp   = {{(CpW-7){1'b0}}, item_i.payload};
            done = 1'b1;
          end
          KindLead: begin
            rem_d  = item_i.lead_len;
            part_d = {{(CpW-7){1'b0}}, item_i.payload};
          end
          default: err_d = 1'b1;
        endcase
      end else if (item_i.kind == KindCont) begin
        part_d = shifted;
        rem_d  = rem_q - 2'd1;
        if (rem_q == 2'd1) begin
          cp   = shifted;
          done = 1'b1;
        end
      end else begin
        // malformed: drop the partial sequence
        err_d  = 1'b1;
        rem_d  = 2'd0;
        part_d = '0;
      end
    end
    if (done) begin
      mark = mark_range(cp);
      if (!first_q) begin
        first_d = 1'b1;
        fmark_d = mark;
      end
      if (!(skip_q && mark) && !(&cnt_q)) begin
        cnt_d = cnt_q + 1'b1;
      end
      part_d = '0;
    end
  end

  always_comb begin
    res_d              = '0;
    res_d.code_point   = cp;
    res_d.point_done   = done;
    res_d.is_diacritic = mark;
    if (item_i.kind == KindTerm) begin
      cnt_ext            = {{CountW{1'b0}}, cnt_q};
      res_d.string_end   = 1'b1;
      res_d.length_error = term_err;
      res_d.string_valid = !term_err && !(first_q && fmark_q);
    end else begin
      cnt_ext            = {{CountW{1'b0}}, cnt_d};
      res_d.length_error = err_d;
    end
    res_d.char_count = cnt_ext[CountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q  <= 1'b0;
      rem_q   <= 2'd0;
      part_q  <= '0;
      cnt_q   <= '0;
      err_q   <= 1'b0;
      first_q <= 1'b0;
      fmark_q <= 1'b0;
    end else begin
      if (cfg_valid_i) skip_q <= cfg_data_i;
      if (item_take_o) begin
        rem_q   <= rem_d;
        part_q  <= part_d;
        cnt_q   <= cnt_d;
        err_q   <= err_d;
        first_q <= first_d;
        fmark_q <= fmark_d;
      end
    end
  end

  // result queue
  assign empty_o = (ocnt_q == 2'd0);
  assign rd_en   = pop_i && !empty_o;
  assign res_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      mem_q[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      ocnt_q   <= 2'd0;
    end else begin
      if (item_take_o) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      if (item_take_o && !rd_en) begin
        ocnt_q <= ocnt_q + 2'd1;
      end else if (rd_en && !item_take_o) begin
        ocnt_q <= ocnt_q - 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_ocnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q != 2'd3) else $error("result queue count out of range");
  a_err_no_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> rem_q == 2'd0) else $error("sequence pending while in error");
  a_done_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o && done |-> !res_d.length_error)
    else $error("code point completed under error");
  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o && item_i.kind == KindTerm |=> rem_q == 2'd0 && cnt_q == '0 && !err_q)
    else $error("string state not cleared at terminator");
  a_valid_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o && res_d.string_valid |-> res_d.string_end)
    else $error("string_valid outside terminator");
`endif

endmodule
`default_nettype wire
